FILE: sv/sem_pkg.sv
// Shared types and constants of the Sobel edge magnitude block.
package sem_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int RING        = 4;
    localparam int RING_W      = $clog2(RING);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [23:0] pixel_t;

    // One column of the 3x3 neighborhood.
    typedef struct packed {
        pixel_t bot;
        pixel_t mid;
        pixel_t top;
    } col_t;

    // A full neighborhood with zero borders applied, plus the frame end mark.
    typedef struct packed {
        logic frame_end;
        col_t right;
        col_t mid;
        col_t left;
    } win_t;

endpackage

FILE: sv/sem_queue.sv
// Short queue of neighborhoods between the window builder and the magnitude unit.
module sem_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sem_pkg::win_t   push_data,
    output logic            full,
    input  logic            pop,
    output sem_pkg::win_t   pop_data,
    output logic            empty
);

    sem_pkg::win_t                    entry_reg [sem_pkg::QUEUE_DEPTH];
    logic [sem_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sem_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sem_pkg::QCNT_W-1:0]       count_reg;
    logic [sem_pkg::QCNT_W-1:0]       count_next;

    assign full     = (count_reg == sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == sem_pkg::QPTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == sem_pkg::QPTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A push never lands on a full queue and a pop never drains an empty one.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue pushed while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: sv/sem_front.sv
// Front part: takes words, keeps the line stores and builds each 3x3 neighborhood.
module sem_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sem_pkg::WIDTH_W-1:0]  w_eff,
    input  logic [sem_pkg::HEIGHT_W-1:0] h_eff,
    input  logic                         restart,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_drain,
    input  sem_pkg::pixel_t              in_pixel,
    output logic                         push,
    output sem_pkg::win_t                push_data,
    input  logic                         full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_PRE  = 3'd1;
    localparam logic [2:0] F_MID  = 3'd2;
    localparam logic [2:0] F_RD   = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;

    logic [sem_pkg::COL_W-1:0]      in_col_reg;
    logic [sem_pkg::ROW_W-1:0]      in_row_reg;
    logic [sem_pkg::COL_W-1:0]      out_col_reg;
    logic [sem_pkg::HEIGHT_W-1:0]   out_row_reg;
    logic                           frame_in_reg;

    logic [sem_pkg::COL_W-1:0]      job_col_reg;
    logic [sem_pkg::ROW_W-1:0]      job_row_reg;
    logic                           job_end_reg;

    sem_pkg::pixel_t                mem [sem_pkg::RING][sem_pkg::MAX_WIDTH];
    sem_pkg::pixel_t                rd_reg [sem_pkg::RING];
    logic                           rd_ok_reg;
    sem_pkg::col_t                  left_reg;
    sem_pkg::col_t                  mid_reg;

    logic                           accept;
    logic                           px_restart;
    logic [sem_pkg::COL_W-1:0]      col_e;
    logic [sem_pkg::ROW_W-1:0]      row_e;
    logic [sem_pkg::COL_W-1:0]      ocol_e;
    logic [sem_pkg::HEIGHT_W-1:0]   orow_e;
    logic                           emit;
    logic                           wr_en;
    logic                           rd_en;
    logic [sem_pkg::COL_W:0]        next_col;
    logic [sem_pkg::COL_W-1:0]      rd_addr;
    logic                           rd_ok;
    sem_pkg::col_t                  cap_col;
    logic [sem_pkg::RING_W-1:0]     bank_mid;
    logic [sem_pkg::HEIGHT_W-1:0]   row_below;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == F_IDLE);

    // Position of this word; a pixel after a complete frame, or beyond the frame size, starts a new one.
    always_comb
    begin
        px_restart = frame_in_reg ||
                     ({1'b0, in_row_reg} >= h_eff) ||
                     ({1'b0, in_col_reg} >= w_eff);
        col_e  = (px_restart && !in_drain) ? '0 : in_col_reg;
        row_e  = (px_restart && !in_drain) ? '0 : in_row_reg;
        ocol_e = (px_restart && !in_drain) ? '0 : out_col_reg;
        orow_e = (px_restart && !in_drain) ? '0 : out_row_reg;
        if (in_drain)
        begin
            emit = frame_in_reg && (out_row_reg < h_eff);
        end
        else
        begin
            emit = (row_e >= sem_pkg::ROW_W'(2)) ||
                   ((row_e == sem_pkg::ROW_W'(1)) && (col_e != '0));
        end
        wr_en = accept && !in_drain;
    end

    // Read address of the column to fetch from all four row banks.
    always_comb
    begin
        next_col = {1'b0, job_col_reg} + 1'b1;
        rd_en    = (state_reg == F_PRE) || (state_reg == F_MID) || (state_reg == F_RD);
        if (state_reg == F_PRE)
        begin
            rd_addr = '0;
            rd_ok   = 1'b1;
        end
        else
        begin
            rd_addr = next_col[sem_pkg::COL_W-1:0];
            rd_ok   = (next_col < w_eff);
        end
    end

    // Column of the neighborhood from the read banks, zero outside the frame.
    always_comb
    begin
        bank_mid    = job_row_reg[sem_pkg::RING_W-1:0];
        row_below   = {1'b0, job_row_reg} + 1'b1;
        cap_col.top = (rd_ok_reg && (job_row_reg != '0)) ? rd_reg[bank_mid - 1'b1] : '0;
        cap_col.mid = rd_ok_reg ? rd_reg[bank_mid] : '0;
        cap_col.bot = (rd_ok_reg && (row_below < h_eff)) ? rd_reg[bank_mid + 1'b1] : '0;
    end

    assign push                = (state_reg == F_PUSH) && !full;
    assign push_data.left      = left_reg;
    assign push_data.mid       = mid_reg;
    assign push_data.right     = cap_col;
    assign push_data.frame_end = job_end_reg;

    // Sequencer of the reads for one neighborhood.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && emit)
                begin
                    state_next = (ocol_e == '0) ? F_PRE : F_RD;
                end
            end
            F_PRE:
            begin
                state_next = F_MID;
            end
            F_MID:
            begin
                state_next = F_PUSH;
            end
            F_RD:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state: counters, frame flag and sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            frame_in_reg <= 1'b0;
        end
        else if (restart)
        begin
            state_reg    <= F_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            frame_in_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (!in_drain)
                begin
                    frame_in_reg <= 1'b0;
                    if (({1'b0, col_e} + 1'b1) >= w_eff)
                    begin
                        in_col_reg <= '0;
                        if (({1'b0, row_e} + 1'b1) >= h_eff)
                        begin
                            in_row_reg   <= '0;
                            frame_in_reg <= 1'b1;
                        end
                        else
                        begin
                            in_row_reg <= row_e + 1'b1;
                        end
                    end
                    else
                    begin
                        in_col_reg <= col_e + 1'b1;
                        in_row_reg <= row_e;
                    end
                    out_col_reg <= ocol_e;
                    out_row_reg <= orow_e;
                end
                if (emit)
                begin
                    if (({1'b0, ocol_e} + 1'b1) >= w_eff)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= orow_e + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= ocol_e + 1'b1;
                        out_row_reg <= orow_e;
                    end
                end
            end
        end
    end

    // Job position and the frame end mark of the result it gives.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            job_col_reg <= ocol_e;
            job_row_reg <= orow_e[sem_pkg::ROW_W-1:0];
            job_end_reg <= (orow_e == h_eff - 1'b1) &&
                           ({1'b0, ocol_e} == w_eff - 1'b1);
        end
    end

    // Row banks: one write of the incoming pixel, one read of a column in all banks.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[row_e[sem_pkg::RING_W-1:0]][col_e] <= in_pixel;
        end
        if (rd_en)
        begin
            for (int b = 0; b < sem_pkg::RING; b++)
            begin
                rd_reg[b] <= mem[b][rd_addr];
            end
            rd_ok_reg <= rd_ok;
        end
    end

    // Sliding window columns.
    always_ff @(posedge clk)
    begin
        if (state_reg == F_MID)
        begin
            left_reg <= '0;
            mid_reg  <= cap_col;
        end
        else if (push)
        begin
            left_reg <= mid_reg;
            mid_reg  <= cap_col;
        end
    end

endmodule

FILE: sv/sem_back.sv
// Back part: Sobel gradients and the clamped rounded magnitude of each channel.
module sem_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  sem_pkg::win_t   pop_data,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [23:0]     out_edges,
    output logic            out_end
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_GRAD = 3'd1;
    localparam logic [2:0] B_SQ   = 3'd2;
    localparam logic [2:0] B_ROOT = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [2:0]      bit_reg;
    sem_pkg::win_t   win_reg;
    logic [9:0]      ax_reg   [3];
    logic [9:0]      ay_reg   [3];
    logic [19:0]     sqx_reg  [3];
    logic [19:0]     sqy_reg  [3];
    logic [7:0]      cand_reg [3];

    logic [9:0]      ax       [3];
    logic [9:0]      ay       [3];
    logic [7:0]      trial    [3];
    logic            take     [3];

    assign pop       = (state_reg == B_IDLE) && !empty;
    assign out_valid = (state_reg == B_OUT);
    assign out_edges = {cand_reg[2], cand_reg[1], cand_reg[0]};
    assign out_end   = win_reg.frame_end;

    // Absolute gradients per channel with 1-2-1 weights.
    always_comb
    begin
        logic [9:0]  lsum;
        logic [9:0]  rsum;
        logic [9:0]  tsum;
        logic [9:0]  bsum;
        logic [21:0] sum_s;
        logic [21:0] lhs;
        for (int c = 0; c < 3; c++)
        begin
            rsum = 10'(win_reg.right.top[8*c +: 8]) + {1'b0, win_reg.right.mid[8*c +: 8], 1'b0}
                   + 10'(win_reg.right.bot[8*c +: 8]);
            lsum = 10'(win_reg.left.top[8*c +: 8]) + {1'b0, win_reg.left.mid[8*c +: 8], 1'b0}
                   + 10'(win_reg.left.bot[8*c +: 8]);
            bsum = 10'(win_reg.left.bot[8*c +: 8]) + {1'b0, win_reg.mid.bot[8*c +: 8], 1'b0}
                   + 10'(win_reg.right.bot[8*c +: 8]);
            tsum = 10'(win_reg.left.top[8*c +: 8]) + {1'b0, win_reg.mid.top[8*c +: 8], 1'b0}
                   + 10'(win_reg.right.top[8*c +: 8]);
            ax[c] = (rsum >= lsum) ? rsum - lsum : lsum - rsum;
            ay[c] = (bsum >= tsum) ? bsum - tsum : tsum - bsum;
            // Round(sqrt(s)) reaches t exactly when t*t - t < s.
            trial[c] = cand_reg[c] | (8'd1 << bit_reg);
            sum_s    = 22'(sqx_reg[c]) + 22'(sqy_reg[c]);
            lhs      = 22'(trial[c]) * 22'(trial[c]);
            take[c]  = lhs < (sum_s + 22'(trial[c]));
        end
    end

    // Sequencer: gradients, squares, then eight steps of a binary search.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_GRAD;
                end
            end
            B_GRAD:
            begin
                state_next = B_SQ;
            end
            B_SQ:
            begin
                state_next = B_ROOT;
            end
            B_ROOT:
            begin
                if (bit_reg == 3'd0)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            bit_reg   <= 3'd7;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_ROOT)
            begin
                bit_reg <= bit_reg - 1'b1;
            end
            else
            begin
                bit_reg <= 3'd7;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            win_reg <= pop_data;
        end
        for (int c = 0; c < 3; c++)
        begin
            if (state_reg == B_GRAD)
            begin
                ax_reg[c] <= ax[c];
                ay_reg[c] <= ay[c];
            end
            if (state_reg == B_SQ)
            begin
                sqx_reg[c]  <= ax_reg[c] * ax_reg[c];
                sqy_reg[c]  <= ay_reg[c] * ay_reg[c];
                cand_reg[c] <= '0;
            end
            if ((state_reg == B_ROOT) && take[c])
            begin
                cand_reg[c] <= trial[c];
            end
        end
    end

endmodule

FILE: sv/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude block with its register port.
// Pixels enter in raster order on the s_ side; each result is the 3x3 Sobel
// magnitude per channel, min(255, round(sqrt(Gx*Gx+Gy*Gy))), with zeros outside
// the frame, and leaves in raster order line_width+1 words behind the input.
// After a frame's last pixel, drain words (tuser 1) release the remaining
// results; m_tlast marks the frame's last pixel. The front takes a word that
// gives no result every cycle; a word that gives a result holds the input
// while the row banks are read to build the window, with an extra read when
// that result starts a new row, and until the queue takes it; the magnitude
// unit pops, runs gradient, square and eight-step root search, and pops the next
// only after that result is taken, which sets the sustained rate. A two-entry
// queue lets the two sides stall apart. Any register write restarts the frame.
module sobel_edge_magnitude_rgb
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tuser,   // req_type
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_edge, green_edge, blue_edge
    output logic        m_tlast    // frame_end
);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [sem_pkg::WIDTH_W-1:0]  width_reg;
    logic [sem_pkg::HEIGHT_W-1:0] height_reg;
    logic [sem_pkg::WIDTH_W-1:0]  w_eff;
    logic [sem_pkg::HEIGHT_W-1:0] h_eff;
    logic                         cfg_wr;
    logic                         push;
    logic                         full;
    logic                         pop;
    logic                         empty;
    sem_pkg::win_t                push_data;
    sem_pkg::win_t                pop_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::WIDTH_W'(640);
            height_reg <= sem_pkg::HEIGHT_W'(480);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[sem_pkg::WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[sem_pkg::HEIGHT_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective frame size, clamped to the supported range.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = sem_pkg::WIDTH_W'(1);
        end
        else if (width_reg > sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH))
        begin
            w_eff = sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = sem_pkg::HEIGHT_W'(1);
        end
        else if (height_reg > sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT))
        begin
            h_eff = sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    sem_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .restart   (cfg_wr),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_drain  (s_tuser),
        .in_pixel  (s_tdata),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    sem_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sem_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_edges (m_tdata),
        .out_end   (m_tlast)
    );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the RGB Sobel edge magnitude block.
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam logic       KIND_PIXEL  = 1'b0;
    localparam logic       KIND_DRAIN  = 1'b1;

    typedef struct packed {
        logic       last;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } edge_word_t;

    // Edge predictor and store of expected edge words.
    class edge_scoreboard;
        int unsigned     wid_reg;
        int unsigned     hgt_reg;
        sem_pkg::pixel_t rows [4][sem_pkg::MAX_WIDTH];
        int unsigned     in_r, in_c, out_r, out_c;
        bit              frame_done;
        edge_word_t      pending [$];
        int              mismatches;

        function new();
            wid_reg = 640;
            hgt_reg = 480;
            mismatches = 0;
            foreach (rows[i, j]) rows[i][j] = '0;
            restart();
        endfunction

        function void restart();
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            frame_done = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] data);
            if (addr == ADDR_WIDTH) wid_reg = data[10:0];
            else hgt_reg = data[12:0];
            restart();
        endfunction

        function int unsigned eff_w();
            return (wid_reg < 1) ? 1 :
                   (wid_reg > sem_pkg::MAX_WIDTH) ? sem_pkg::MAX_WIDTH : wid_reg;
        endfunction

        function int unsigned eff_h();
            return (hgt_reg < 1) ? 1 :
                   (hgt_reg > sem_pkg::MAX_HEIGHT) ? sem_pkg::MAX_HEIGHT : hgt_reg;
        endfunction

        function int sample(int r, int c, int w, int h, int ch);
            sem_pkg::pixel_t p;
            if (r < 0 || c < 0 || r >= h || c >= w) return 0;
            p = rows[r & 3][c];
            return p[ch*8 +: 8];
        endfunction

        // Rounded magnitude: round(sqrt(s)) >= m exactly when s > m*m - m.
        function logic [7:0] root_round(int gx, int gy);
            int unsigned s, n;
            s = gx * gx + gy * gy;
            n = 0;
            for (int unsigned m = 1; m <= 255; m++)
            begin
                if (s > m * m - m) n = m;
                else break;
            end
            return n[7:0];
        endfunction

        function void predict_word();
            int         r, c, w, h;
            int         tl, tm, tr, ml, mr, bl, bm, br;
            logic [7:0] mag [3];
            edge_word_t ew;
            w = eff_w(); h = eff_h(); r = out_r; c = out_c;
            for (int ch = 0; ch < 3; ch++)
            begin
                tl = sample(r-1, c-1, w, h, ch); tm = sample(r-1, c, w, h, ch);
                tr = sample(r-1, c+1, w, h, ch); ml = sample(r, c-1, w, h, ch);
                mr = sample(r, c+1, w, h, ch);   bl = sample(r+1, c-1, w, h, ch);
                bm = sample(r+1, c, w, h, ch);   br = sample(r+1, c+1, w, h, ch);
                mag[ch] = root_round((tr + 2*mr + br) - (tl + 2*ml + bl),
                                     (bl + 2*bm + br) - (tl + 2*tm + tr));
            end
            ew.r = mag[0]; ew.g = mag[1]; ew.b = mag[2];
            ew.last = (out_r == h - 1 && out_c == w - 1);
            pending.push_back(ew);
            out_c++;
            if (out_c >= w)
            begin
                out_c = 0;
                out_r++;
            end
        endfunction

        // Note one accepted input word.
        function void note_input(logic kind, sem_pkg::pixel_t pix);
            int unsigned w, h;
            bit          fire;
            w = eff_w(); h = eff_h();
            if (kind == KIND_PIXEL)
            begin
                if (frame_done) restart();
                if (in_r >= h || in_c >= w) restart();
                fire = (in_r * w + in_c) >= w + 1;
                if (in_c == 0 && fire) predict_word();
                rows[in_r & 3][in_c] = pix;
                if (in_c != 0 && fire) predict_word();
                in_c++;
                if (in_c >= w)
                begin
                    in_c = 0;
                    in_r++;
                    if (in_r >= h)
                    begin
                        in_r = 0;
                        frame_done = 1;
                    end
                end
            end
            else if (frame_done && out_r < h)
            begin
                predict_word();
            end
        endfunction

        // Check one accepted output word.
        function void check_output(edge_word_t got);
            edge_word_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.r !== want.r || got.g !== want.g || got.b !== want.b
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected r%0d g%0d b%0d l%0d, got r%0d g%0d b%0d l%0d",
                             want.r, want.g, want.b, want.last,
                             got.r, got.g, got.b, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        s_tvalid, s_tready, s_tuser;
    logic [23:0] s_tdata;
    logic        m_tvalid, m_tready, m_tlast;
    logic [23:0] m_tdata;

    edge_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;

    sobel_edge_magnitude_rgb dut (.*);

    // Clock.
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        #50ms;
        $display("sobel_edge_magnitude_rgb test failed");
        $finish;
    end

    // Receiver: random stalls plus a long hold-off when requested.
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output({m_tlast, m_tdata[23:16], m_tdata[15:8], m_tdata[7:0]});
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(addr, data);
    endtask

    // Send one word; valid stays high across back-to-back words.
    task automatic send_word(logic kind, sem_pkg::pixel_t pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1; s_tuser <= kind; s_tdata <= pix;
        do @(posedge clk); while (!s_tready);
        sb.note_input(kind, pix);
    endtask

    task automatic wait_idle();
        int guard;
        s_tvalid <= 0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        wait_idle();
        reg_write(ADDR_WIDTH, w);
        reg_write(ADDR_HEIGHT, h);
    endtask

    // One frame of pixels followed by the drain words; pattern picks content.
    task automatic run_frame(int unsigned w, int unsigned h, int pattern, int extra);
        sem_pkg::pixel_t p;
        for (int unsigned i = 0; i < w * h; i++)
        begin
            case (pattern)
                0: p = 24'($urandom);
                1: p = (i % 2) ? 24'hFFFFFF : 24'h000000;
                default: p = ($urandom_range(1)) ? 24'hFFFFFF : 24'h000000;
            endcase
            send_word(KIND_PIXEL, p);
        end
        for (int unsigned i = 0; i < w + 1 + extra; i++)
            send_word(KIND_DRAIN, 24'($urandom));
    endtask

    initial
    begin
        int unsigned w, h;
        sb = new();
        rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tuser = 0; s_tdata = 0;
        send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: drain before any frame, smallest and degenerate sizes.
        send_idle_pct = 22; recv_idle_pct = 70;
        send_word(KIND_DRAIN, 0);
        set_size(0, 0);
        run_frame(1, 1, 1, 1);
        set_size(3, 2);
        run_frame(3, 2, 1, 1);
        set_size(2, 3);
        send_word(KIND_PIXEL, 24'hFFFFFF);
        send_word(KIND_DRAIN, 0);
        run_frame(2, 3, 2, 0);
        // Pixel after a complete frame starts a new one, dropping undrained words.
        run_frame(2, 3, 0, 0);
        run_frame(2, 3, 0, 0);

        // Random frames over three idling phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 22 : 0;
            for (int f = 0; f < 8; f++)
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                // A full-size frame under a long receiver hold-off fills the block.
                if (phase == 2 && f == 0)
                begin
                    w = 8;
                    h = 6;
                end
                set_size(w, h);
                if (phase == 2 && f == 0) hold_cycles = 300;
                run_frame(w, h, $urandom_range(2), $urandom_range(1));
            end
        end

        // Wide rows: a partial two-row frame reaches far columns.
        set_size(450, 2);
        for (int i = 0; i < 460; i++) send_word(KIND_PIXEL, 24'($urandom));

        // Tall frame extremes, plus an out-of-range height.
        set_size(1, 4096);
        send_idle_pct = 0;
        for (int i = 0; i < 40; i++) send_word(KIND_PIXEL, 24'($urandom));
        set_size(1, 8191);
        for (int i = 0; i < 20; i++) send_word(KIND_PIXEL, 24'($urandom));

        wait_idle();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("sobel_edge_magnitude_rgb test passed");
        else
            $display("sobel_edge_magnitude_rgb test failed");
        $finish;
    end
endmodule
